>>> hw/rtl/lwtlv_pkg.sv
// ----------------------------------------------------------------------------
// lwtlv_pkg
// Types, constants and helper functions for the TLV stream deframer.
// ----------------------------------------------------------------------------
package lwtlv_pkg;

  localparam int MaxDepth  = 3;
  localparam int NumLevels = 3;
  localparam int LevelW    = 2;
  localparam int IdW       = 16;
  localparam int LenW      = 24;
  localparam int IntW      = 64;

  // type byte fields
  localparam int TypeIdWideBit = 5;
  localparam int TypeLenHi     = 4;
  localparam int TypeLenLo     = 3;
  localparam int TypeInlineHi  = 2;

  localparam logic [1:0] ItemMultiRes = 2'd2;

  typedef enum logic [2:0] {
    PhType,
    PhId,
    PhLen,
    PhValue,
    PhHalt
  } phase_e;

  typedef enum logic [1:0] {
    EvHdrByte,
    EvHdrDone,
    EvValue,
    EvError
  } event_e;

  typedef enum logic [1:0] {
    ErrNone,
    ErrTrunc,
    ErrOverrun
  } error_e;

  typedef logic [NumLevels-1:0][LenW-1:0] rem_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    event_e            kind;
    logic [LevelW-1:0] nest_level;
    logic [1:0]        item_type;
    logic [IdW-1:0]    item_id;
    logic [LenW-1:0]   item_length;
    logic              is_container;
    logic [7:0]        value_byte;
    logic              value_last;
    logic [IntW-1:0]   accum_value;
    error_e            error_code;
  } result_t;

  // clamp the configured start level to a usable level
  function automatic logic [LevelW-1:0] top_level(logic [LevelW-1:0] sl);
    logic [LevelW-1:0] s;
    s = sl;
    if (int'(s) > NumLevels - 1) s = LevelW'(NumLevels - 1);
    if (int'(s) > MaxDepth - 1) s = LevelW'(MaxDepth - 1);
    return s;
  endfunction

  // step back out of levels whose byte budget is used up
  function automatic logic [LevelW-1:0] pop_level(logic [LevelW-1:0] cur,
                                                  logic [LevelW-1:0] s,
                                                  rem_t rem);
    logic [LevelW-1:0] c;
    c = cur;
    for (int i = 0; i < NumLevels - 1; i++) begin
      if (c > s && rem[c] == '0) c = c - 1'b1;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/lwtlv_parser.sv
// ----------------------------------------------------------------------------
// lwtlv_parser
// Parse state and the per-byte update: header fields, level byte budgets,
// value accumulation, truncation and overrun detection.
// ----------------------------------------------------------------------------
module lwtlv_parser import lwtlv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  in_item_t          item_i,
  input  logic [LevelW-1:0] start_level_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        type_q, type_d;
  logic [1:0]        fbl_q, fbl_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [LenW-1:0]   len_q, len_d;
  rem_t              rem_q, rem_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic [LenW-1:0]   pl_q, pl_d;
  logic [IntW-1:0]   va_q, va_d;

  // effective state (after message start and level normalization)
  logic [LevelW-1:0] s;
  phase_e            ph_e;
  logic [7:0]        type_e;
  logic [1:0]        fbl_e;
  logic [IdW-1:0]    id_e;
  logic [LenW-1:0]   len_e;
  rem_t              rem_e;
  logic [LevelW-1:0] lvl_e;
  logic [LenW-1:0]   pl_e;
  logic [IntW-1:0]   va_e;

  // updated state
  phase_e            ph_u;
  logic [7:0]        type_u;
  logic [1:0]        fbl_u;
  logic [IdW-1:0]    id_u;
  logic [LenW-1:0]   len_u;
  rem_t              rem_u;
  logic [LevelW-1:0] lvl_u;
  logic [LenW-1:0]   pl_u;
  logic [IntW-1:0]   va_u;

  event_e            kind_u;
  logic              cont_u;
  logic [7:0]        vb_u;
  logic              last_u;
  logic [IntW-1:0]   ival_u;
  logic              room_err;
  logic              over;
  logic              hdr;
  logic              cont;
  logic              err2;
  logic [1:0]        fleft;

  always_comb begin
    s = top_level(start_level_i);
    if (item_i.message_start) begin
      ph_e   = PhType;
      type_e = '0;
      fbl_e  = '0;
      id_e   = '0;
      len_e  = '0;
      rem_e  = '0;
      lvl_e  = s;
      pl_e   = '0;
      va_e   = '0;
    end else begin
      ph_e   = phase_q;
      type_e = type_q;
      fbl_e  = fbl_q;
      id_e   = id_q;
      len_e  = len_q;
      rem_e  = rem_q;
      lvl_e  = lvl_q;
      pl_e   = pl_q;
      va_e   = va_q;
    end
    if (lvl_e < s || int'(lvl_e) > NumLevels - 1) lvl_e = s;
  end

  // datapath for one byte
  always_comb begin
    ph_u   = ph_e;
    type_u = type_e;
    fbl_u  = fbl_e;
    id_u   = id_e;
    len_u  = len_e;
    rem_u  = rem_e;
    lvl_u  = lvl_e;
    pl_u   = pl_e;
    va_u   = va_e;
    kind_u = EvHdrByte;
    cont_u = 1'b0;
    vb_u   = '0;
    last_u = 1'b0;
    ival_u = '0;
    hdr    = 1'b0;
    over   = 1'b0;
    cont   = 1'b0;
    fleft  = '0;

    // header byte with nothing left in the parent
    room_err = (ph_e == PhId || ph_e == PhLen) && lvl_e > s && rem_e[lvl_e] == '0;

    if (!room_err && ph_e != PhHalt) begin
      for (int l = 0; l < NumLevels; l++) begin
        if (LevelW'(l) > s && LevelW'(l) <= lvl_e && rem_e[l] != '0) begin
          rem_u[l] = rem_e[l] - 1'b1;
        end
      end

      unique case (ph_e)
        PhType: begin
          type_u = item_i.data_byte;
          id_u   = '0;
          len_u  = '0;
          fbl_u  = item_i.data_byte[TypeIdWideBit] ? 2'd2 : 2'd1;
          ph_u   = PhId;
        end
        PhId: begin
          id_u  = {id_e[IdW-9:0], item_i.data_byte};
          fleft = fbl_e - 1'b1;
          fbl_u = fleft;
          if (fleft == '0) begin
            fbl_u = type_e[TypeLenHi:TypeLenLo];
            if (type_e[TypeLenHi:TypeLenLo] != '0) begin
              ph_u  = PhLen;
              len_u = '0;
            end else begin
              len_u = LenW'(type_e[TypeInlineHi:0]);
              hdr   = 1'b1;
            end
          end
        end
        PhLen: begin
          len_u = {len_e[LenW-9:0], item_i.data_byte};
          fleft = fbl_e - 1'b1;
          fbl_u = fleft;
          if (fleft == '0) hdr = 1'b1;
        end
        PhValue: begin
          va_u   = {va_e[IntW-9:0], item_i.data_byte};
          pl_u   = (pl_e != '0) ? pl_e - 1'b1 : pl_e;
          kind_u = EvValue;
          vb_u   = item_i.data_byte;
          last_u = (pl_u == '0);
          ival_u = va_u;
          if (pl_u == '0) begin
            ph_u  = PhType;
            lvl_u = pop_level(lvl_e, s, rem_u);
          end
        end
        default: begin
        end
      endcase

      if (hdr) begin
        cont = (lvl_e == '0 || (lvl_e == LevelW'(1) && type_e[7:6] == ItemMultiRes)) &&
               (int'(lvl_e) + 1 < MaxDepth);
        over = lvl_e > s && len_u > rem_u[lvl_e];
        if (!over) begin
          kind_u = EvHdrDone;
          cont_u = cont;
          last_u = (len_u == '0);
          va_u   = '0;
          if (len_u == '0) begin
            ph_u  = PhType;
            lvl_u = pop_level(lvl_e, s, rem_u);
          end else if (cont) begin
            lvl_u                 = lvl_e + 1'b1;
            rem_u[lvl_e + 1'b1]   = len_u;
            ph_u                  = PhType;
          end else begin
            pl_u = len_u;
            ph_u = PhValue;
          end
        end
      end
    end

    err2 = room_err || over;
  end

  // next state
  always_comb begin
    if (item_i.message_end) begin
      phase_d = PhType;
      type_d  = '0;
      fbl_d   = '0;
      id_d    = '0;
      len_d   = '0;
      rem_d   = '0;
      lvl_d   = s;
      pl_d    = '0;
      va_d    = '0;
    end else begin
      phase_d = err2 ? PhHalt : ph_u;
      type_d  = type_u;
      fbl_d   = fbl_u;
      id_d    = id_u;
      len_d   = len_u;
      rem_d   = rem_u;
      lvl_d   = lvl_u;
      pl_d    = pl_u;
      va_d    = va_u;
    end
  end

  // result
  always_comb begin
    res_valid_o        = (ph_e != PhHalt);
    res_o.item_type    = type_u[7:6];
    res_o.item_id      = id_u;
    res_o.item_length  = len_u;
    if (err2) begin
      res_o.kind         = EvError;
      res_o.nest_level   = lvl_e;
      res_o.is_container = 1'b0;
      res_o.value_byte   = '0;
      res_o.value_last   = 1'b0;
      res_o.accum_value  = va_u;
      res_o.error_code   = ErrOverrun;
    end else if (item_i.message_end && !(ph_u == PhType && lvl_u == s)) begin
      res_o.kind         = EvError;
      res_o.nest_level   = lvl_u;
      res_o.is_container = 1'b0;
      res_o.value_byte   = '0;
      res_o.value_last   = 1'b0;
      res_o.accum_value  = va_u;
      res_o.error_code   = ErrTrunc;
    end else begin
      res_o.kind         = kind_u;
      res_o.nest_level   = lvl_e;
      res_o.is_container = cont_u;
      res_o.value_byte   = vb_u;
      res_o.value_last   = last_u;
      res_o.accum_value  = ival_u;
      res_o.error_code   = ErrNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      type_q  <= '0;
      fbl_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      lvl_q   <= '0;
      pl_q    <= '0;
      va_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      fbl_q   <= fbl_d;
      id_q    <= id_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      lvl_q   <= lvl_d;
      pl_q    <= pl_d;
      va_q    <= va_d;
    end
  end

endmodule

>>> hw/rtl/lwtlv_out_reg.sv
// ----------------------------------------------------------------------------
// lwtlv_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module lwtlv_out_reg import lwtlv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/lwm2m_tlv_stream_deframer.sv
// ----------------------------------------------------------------------------
// lwm2m_tlv_stream_deframer
// Byte-wide TLV deframer: one event per byte, except while halted after error.
// ----------------------------------------------------------------------------
// Flow: a byte accepted into the input register is parsed combinationally, and
// its event is loaded into the result register when the parser steps.
// Throughput: one byte per cycle unless a full, unread result register stalls
// the parse update between the input register and the result register.
// Reset: asynchronous, active low; parser at top level, start_level = 0.
module lwm2m_tlv_stream_deframer import lwtlv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LevelW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              message_start_i,
  input  logic              message_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        event_kind_o,
  output logic [LevelW-1:0] nest_level_o,
  output logic [1:0]        item_type_o,
  output logic [IdW-1:0]    item_id_o,
  output logic [LenW-1:0]   item_length_o,
  output logic              is_container_o,
  output logic [7:0]        value_byte_o,
  output logic              value_last_o,
  output logic [IntW-1:0]   accum_value_o,
  output logic [1:0]        error_code_o
);

  logic [LevelW-1:0] start_level_q;
  logic              in_valid_q;
  in_item_t          item_q;
  logic              step;
  logic              res_valid;
  logic              out_free;
  result_t           res;
  result_t           res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q <= '0;
    end else if (cfg_we_i) begin
      start_level_q <= cfg_wdata_i;
    end
  end

  // a byte with no event (halted) moves on regardless of the output side
  assign step       = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.data_byte     <= data_byte_i;
      item_q.message_start <= message_start_i;
      item_q.message_end   <= message_end_i;
    end
  end

  lwtlv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item_q),
    .start_level_i (start_level_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lwtlv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_out)
  );

  assign event_kind_o   = res_out.kind;
  assign nest_level_o   = res_out.nest_level;
  assign item_type_o    = res_out.item_type;
  assign item_id_o      = res_out.item_id;
  assign item_length_o  = res_out.item_length;
  assign is_container_o = res_out.is_container;
  assign value_byte_o   = res_out.value_byte;
  assign value_last_o   = res_out.value_last;
  assign accum_value_o  = res_out.accum_value;
  assign error_code_o   = res_out.error_code;

endmodule
